>>> rtl/core/srwf_pkg.sv
// srwf_pkg: shared types, constants and helpers of the separable rgb window filter
// no dependencies; used by srwf_ctrl, srwf_dpath and the top level
`timescale 1ns / 1ps
`default_nettype none

package srwf_pkg;

   localparam int PIX_W      = 32;
   localparam int RGB_W      = 24;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int COEF_W     = 16;
   localparam int NUM_COEF   = 15;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int FRAC_W     = 16;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hff;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH  = 4'd0,
      REG_HEIGHT = 4'd1,
      REG_RADIUS = 4'd2,
      REG_BYPASS = 4'd3,
      REG_COEF_A = 4'd4,
      REG_COEF_B = 4'd5,
      REG_COEF_C = 4'd6,
      REG_COEF_D = 4'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_BYP_RD,
      ST_BYP_DONE,
      ST_DIV,
      ST_COL_START,
      ST_TAP_RD,
      ST_TAP_MAC,
      ST_COL_NEXT,
      ST_FIN
   } ctl_state_type;

   typedef struct packed {
      logic req_ready;
      logic eval;
      logic byp_rd;
      logic out_byp;
      logic div_step;
      logic col_init;
      logic col_start;
      logic tap_rd;
      logic tap_mac;
      logic col_next;
      logic out_filt;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic has_out;
      logic bypass;
      logic div_done;
      logic col_valid;
      logic last_tap;
      logic last_col;
      logic out_free;
   } status_type;

   // drop the fraction and clip at full scale
   function automatic logic [CHAN_W-1:0] sat_chan(input logic [31:0] acc);
      logic [15:0] v;
      v = acc[31:FRAC_W];
      if (v > 16'(CHAN_MAX)) begin
         return CHAN_MAX;
      end
      return v[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/srwf_ifs.sv
// srwf_ifs: handshake channels of the filter (pixel in, pixel out, register writes)
// depends on nothing; widths match srwf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface srwf_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] pixel_in;
   modport source (output valid, operation, pixel_in, input ready);
   modport sink   (input valid, operation, pixel_in, output ready);
endinterface

interface srwf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic        frame_last;
   modport source (output valid, pixel_out, frame_last, input ready);
   modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

interface srwf_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/srwf_ram.sv
// srwf_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module srwf_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/srwf_ctrl.sv
// srwf_ctrl: sequencing state machine of the filter
// depends on srwf_pkg (state, command and status types)
`timescale 1ns / 1ps
`default_nettype none

module srwf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire srwf_pkg::status_type   status,
   output srwf_pkg::cmd_type           cmd
);

   srwf_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srwf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srwf_pkg::ST_IDLE: begin
            if (req_valid) state_in = srwf_pkg::ST_EVAL;
         end
         srwf_pkg::ST_EVAL: begin
            if (status.skip || !status.has_out) state_in = srwf_pkg::ST_IDLE;
            else if (status.bypass)             state_in = srwf_pkg::ST_BYP_RD;
            else                                state_in = srwf_pkg::ST_DIV;
         end
         srwf_pkg::ST_BYP_RD:    state_in = srwf_pkg::ST_BYP_DONE;
         srwf_pkg::ST_BYP_DONE: begin
            if (status.out_free) state_in = srwf_pkg::ST_IDLE;
         end
         srwf_pkg::ST_DIV: begin
            if (status.div_done) state_in = srwf_pkg::ST_COL_START;
         end
         srwf_pkg::ST_COL_START: begin
            state_in = status.col_valid ? srwf_pkg::ST_TAP_RD : srwf_pkg::ST_COL_NEXT;
         end
         srwf_pkg::ST_TAP_RD:    state_in = srwf_pkg::ST_TAP_MAC;
         srwf_pkg::ST_TAP_MAC: begin
            state_in = status.last_tap ? srwf_pkg::ST_COL_NEXT : srwf_pkg::ST_TAP_RD;
         end
         srwf_pkg::ST_COL_NEXT: begin
            state_in = status.last_col ? srwf_pkg::ST_FIN : srwf_pkg::ST_COL_START;
         end
         srwf_pkg::ST_FIN: begin
            if (status.out_free) state_in = srwf_pkg::ST_IDLE;
         end
         default: state_in = srwf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         srwf_pkg::ST_IDLE:      cmd.req_ready = 1'b1;
         srwf_pkg::ST_EVAL:      cmd.eval      = 1'b1;
         srwf_pkg::ST_BYP_RD:    cmd.byp_rd    = 1'b1;
         srwf_pkg::ST_BYP_DONE:  cmd.out_byp   = status.out_free;
         srwf_pkg::ST_DIV: begin
            cmd.div_step = !status.div_done;
            cmd.col_init = status.div_done;
         end
         srwf_pkg::ST_COL_START: cmd.col_start = 1'b1;
         srwf_pkg::ST_TAP_RD:    cmd.tap_rd    = 1'b1;
         srwf_pkg::ST_TAP_MAC:   cmd.tap_mac   = 1'b1;
         srwf_pkg::ST_COL_NEXT:  cmd.col_next  = 1'b1;
         srwf_pkg::ST_FIN:       cmd.out_filt  = status.out_free;
         default:                cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/srwf_dpath.sv
// srwf_dpath: counters, line and bypass memories, divider, shared mac and output word
// depends on srwf_pkg and srwf_ram
`timescale 1ns / 1ps
`default_nettype none

module srwf_dpath #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 7
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire srwf_pkg::cmd_type                     cmd,
   output srwf_pkg::status_type                       status,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_op,
   input  wire logic [srwf_pkg::PIX_W-1:0]            req_pix,
   input  wire logic                                  bypass,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       height,
   input  wire logic [$clog2(MAX_RADIUS+1)-1:0]       radius,
   input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] total,
   input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT+MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1)-1:0] lat,
   input  wire logic [srwf_pkg::NUM_COEF*srwf_pkg::COEF_W-1:0] coef_all,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [srwf_pkg::PIX_W-1:0]                 rsp_pixel,
   output logic                                       rsp_last
);

   localparam int W_W    = $clog2(MAX_WIDTH+1);
   localparam int H_W    = $clog2(MAX_HEIGHT+1);
   localparam int CNT_W  = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);
   localparam int TAP_W  = $clog2(2*MAX_RADIUS+1);
   localparam int LINE_DEPTH = 2**$clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+1);
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int BYP_DEPTH  = 2**$clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);
   localparam int BYP_AW     = $clog2(BYP_DEPTH);
   localparam int ACC_W  = srwf_pkg::CHAN_W + srwf_pkg::COEF_W + TAP_W;
   localparam int C_W    = W_W + 2;
   localparam int Y_W    = H_W + 2;
   localparam int DIVC_W = $clog2(CNT_W+1);
   localparam int PROD_W = srwf_pkg::CHAN_W + srwf_pkg::COEF_W;

   // item and frame position
   logic                         op_ff;
   logic [srwf_pkg::PIX_W-1:0]   pix_ff;
   logic [CNT_W-1:0]             t_ff, t_in;
   logic [CNT_W-1:0]             n_ff;
   logic                         last_ff;
   logic [CNT_W-1:0]             tot_ext, n_c;
   logic                         in_frame, below_lat, end_c;

   // divider
   logic [CNT_W-1:0]             div_q_ff;
   logic [W_W-1:0]               div_rem_ff;
   logic [DIVC_W-1:0]            div_cnt_ff;
   logic [W_W:0]                 rem_sh;
   logic                         rem_ge;

   // window walk
   logic [TAP_W-1:0]             k_ff, m_ff, last_idx;
   logic signed [C_W-1:0]        c_ff;
   logic signed [Y_W-1:0]        y_ff;
   logic [LINE_AW-1:0]           pcol_ff, p_ff;
   logic                         yv_ff;
   logic [ACC_W-1:0]             vacc_ff [srwf_pkg::NUM_CHAN];
   logic [ACC_W-1:0]             hacc_ff [srwf_pkg::NUM_CHAN];

   // shared multiplier
   logic [srwf_pkg::RGB_W-1:0]   vpack, hpack, mul_rgb;
   logic [TAP_W-1:0]             mul_idx;
   logic [srwf_pkg::COEF_W-1:0]  mul_w;
   logic [PROD_W-1:0]            prod [srwf_pkg::NUM_CHAN];

   // memories
   logic [srwf_pkg::RGB_W-1:0]   line_rd_data;
   logic [srwf_pkg::PIX_W-1:0]   byp_rd_data;
   logic                         mem_we;

   logic                         out_free;

   assign tot_ext   = CNT_W'(total);
   assign in_frame  = t_ff < tot_ext;
   assign below_lat = t_ff < lat;
   assign n_c       = t_ff - lat;
   assign end_c     = !below_lat && (n_c >= tot_ext - CNT_W'(1));
   assign mem_we    = cmd.eval && in_frame && (op_ff == srwf_pkg::OP_PIXEL);

   always_comb begin
      t_in = t_ff;
      if (cmd.eval && !(in_frame && (op_ff == srwf_pkg::OP_DRAIN))) begin
         if (below_lat)  t_in = t_ff + CNT_W'(1);
         else if (end_c) t_in = '0;
         else            t_in = t_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff <= '0;
      end else begin
         t_ff <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && cmd.req_ready) begin
         op_ff  <= req_op;
         pix_ff <= req_pix;
      end
      if (cmd.eval) begin
         n_ff    <= n_c;
         last_ff <= (n_c == tot_ext - CNT_W'(1));
      end
   end

   // restoring divide of the output index by the width: row and column
   assign rem_sh = {div_rem_ff, div_q_ff[CNT_W-1]};
   assign rem_ge = rem_sh >= {1'b0, width};

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         div_q_ff   <= n_c;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_q_ff   <= {div_q_ff[CNT_W-2:0], rem_ge};
         div_rem_ff <= rem_ge ? W_W'(rem_sh - {1'b0, width}) : W_W'(rem_sh);
         div_cnt_ff <= div_cnt_ff + DIVC_W'(1);
      end
   end

   // coefficient pick, taps past the last one weigh nothing
   assign mul_idx = cmd.tap_mac ? m_ff : k_ff;
   always_comb begin
      mul_w = '0;
      if (32'(mul_idx) < srwf_pkg::NUM_COEF) begin
         mul_w = coef_all[srwf_pkg::COEF_W*int'(mul_idx) +: srwf_pkg::COEF_W];
      end
   end

   always_comb begin
      for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) begin
         vpack[ch*srwf_pkg::CHAN_W +: srwf_pkg::CHAN_W] = srwf_pkg::sat_chan(32'(vacc_ff[ch]));
         hpack[ch*srwf_pkg::CHAN_W +: srwf_pkg::CHAN_W] = srwf_pkg::sat_chan(32'(hacc_ff[ch]));
      end
   end

   assign mul_rgb = cmd.tap_mac ? line_rd_data : vpack;

   always_comb begin
      for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) begin
         prod[ch] = PROD_W'(mul_rgb[ch*srwf_pkg::CHAN_W +: srwf_pkg::CHAN_W]) * PROD_W'(mul_w);
      end
   end

   assign last_idx = TAP_W'({radius, 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.col_init) begin
         k_ff    <= '0;
         c_ff    <= $signed({2'b00, div_rem_ff}) - $signed(C_W'(radius));
         pcol_ff <= LINE_AW'(n_ff - lat);
         for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) hacc_ff[ch] <= '0;
      end else if (cmd.col_next) begin
         k_ff    <= k_ff + TAP_W'(1);
         c_ff    <= c_ff + C_W'(1);
         pcol_ff <= pcol_ff + LINE_AW'(1);
         for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) begin
            hacc_ff[ch] <= hacc_ff[ch] + ACC_W'(prod[ch]);
         end
      end
      if (cmd.col_start) begin
         m_ff <= '0;
         y_ff <= $signed({2'b00, div_q_ff[H_W-1:0]}) - $signed(Y_W'(radius));
         p_ff <= pcol_ff;
         for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) vacc_ff[ch] <= '0;
      end else if (cmd.tap_mac) begin
         m_ff <= m_ff + TAP_W'(1);
         y_ff <= y_ff + Y_W'(1);
         p_ff <= p_ff + LINE_AW'(width);
         if (yv_ff) begin
            for (int ch = 0; ch < srwf_pkg::NUM_CHAN; ch++) begin
               vacc_ff[ch] <= vacc_ff[ch] + ACC_W'(prod[ch]);
            end
         end
      end
      if (cmd.tap_rd) begin
         yv_ff <= (y_ff >= 0) && (y_ff < $signed({2'b00, height}));
      end
   end

   srwf_ram #(
      .DATA_W (srwf_pkg::RGB_W),
      .DEPTH  (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (t_ff[LINE_AW-1:0]),
      .wr_data (pix_ff[srwf_pkg::RGB_W-1:0]),
      .rd_en   (cmd.tap_rd),
      .rd_addr (p_ff),
      .rd_data (line_rd_data)
   );

   srwf_ram #(
      .DATA_W (srwf_pkg::PIX_W),
      .DEPTH  (BYP_DEPTH)
   ) u_byp_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (t_ff[BYP_AW-1:0]),
      .wr_data (pix_ff),
      .rd_en   (cmd.byp_rd),
      .rd_addr (n_ff[BYP_AW-1:0]),
      .rd_data (byp_rd_data)
   );

   // output word register
   assign out_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_byp || cmd.out_filt) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_byp) begin
         rsp_pixel <= byp_rd_data;
         rsp_last  <= last_ff;
      end else if (cmd.out_filt) begin
         rsp_pixel <= {srwf_pkg::ALPHA_OPAQUE, hpack};
         rsp_last  <= last_ff;
      end
   end

   always_comb begin
      status           = '0;
      status.skip      = in_frame && (op_ff == srwf_pkg::OP_DRAIN);
      status.has_out   = !below_lat && (n_c < tot_ext);
      status.bypass    = bypass;
      status.div_done  = div_cnt_ff == DIVC_W'(CNT_W);
      status.col_valid = (c_ff >= 0) && (c_ff < $signed({2'b00, width}));
      status.last_tap  = m_ff == last_idx;
      status.last_col  = k_ff == last_idx;
      status.out_free  = out_free;
   end

endmodule

`default_nettype wire

>>> rtl/core/separable_rgb_window_filter.sv
// separable_rgb_window_filter: top level, register file, geometry and the two halves
// depends on srwf_pkg, srwf_ifs, srwf_ctrl, srwf_dpath (and srwf_ram below it)
`timescale 1ns / 1ps
`default_nettype none

// Streams one frame of packed pixels in raster order, then drain words, and returns
// for every frame pixel a 2r+1 tap vertical then horizontal filtered pixel with alpha
// forced opaque (or the input pixel unchanged in bypass mode). Pixel n of the frame
// leaves on the word whose index is n + r*width + r; drain words ahead of that
// produce nothing, and the frame restarts after the word that delivers the last pixel.
// One word is worked on at a time. A word with no result is evaluated and dropped; a
// bypass result is read from the bypass memory and then waits on the output. A filtered
// result runs the one-bit-a-cycle row/column divider over the word index (CNT_W is 24
// at the default sizes), then for each column accumulates its taps on the single shared
// multiply-accumulate, which reads the line memory one tap at a time; a column outside
// the frame skips its taps. The filtered result then waits on the output.
// A finished word waits in the output register while the next input word is taken.
// The line and bypass memories need no clearing pass after reset. Register writes
// are accepted every cycle and must come while the block is idle; their geometry
// takes effect once it has passed the clamped geometry registers.

module separable_rgb_window_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 7
) (
   input  wire logic    clock,
   input  wire logic    reset,
   srwf_req_if.sink     req_ch,
   srwf_rsp_if.source   rsp_ch,
   srwf_csr_if.sink     csr_ch
);

   localparam int W_W   = $clog2(MAX_WIDTH+1);
   localparam int H_W   = $clog2(MAX_HEIGHT+1);
   localparam int R_W   = $clog2(MAX_RADIUS+1);
   localparam int TOT_W = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
   localparam int CNT_W = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+1);

   // register file
   logic [11:0] cfg_width_ff;
   logic [12:0] cfg_height_ff;
   logic [2:0]  cfg_radius_ff;
   logic        cfg_bypass_ff;
   logic [63:0] cfg_coef_a_ff, cfg_coef_b_ff, cfg_coef_c_ff;
   logic [47:0] cfg_coef_d_ff;

   // clamped geometry, registered after the multiplies
   logic [W_W-1:0]   w_eff, w_ff;
   logic [H_W-1:0]   h_eff, h_ff;
   logic [R_W-1:0]   r_eff, r_ff;
   logic [TOT_W-1:0] total_ff;
   logic [CNT_W-1:0] lat_ff;

   srwf_pkg::cmd_type    cmd;
   srwf_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 12'd640;
         cfg_height_ff <= 13'd480;
         cfg_radius_ff <= 3'd2;
         cfg_bypass_ff <= 1'b0;
         cfg_coef_a_ff <= '0;
         cfg_coef_b_ff <= '0;
         cfg_coef_c_ff <= '0;
         cfg_coef_d_ff <= '0;
      end else if (csr_ch.valid) begin
         case (srwf_pkg::csr_reg_type'(csr_ch.index))
            srwf_pkg::REG_WIDTH:  cfg_width_ff  <= csr_ch.data[11:0];
            srwf_pkg::REG_HEIGHT: cfg_height_ff <= csr_ch.data[12:0];
            srwf_pkg::REG_RADIUS: cfg_radius_ff <= csr_ch.data[2:0];
            srwf_pkg::REG_BYPASS: cfg_bypass_ff <= csr_ch.data[0];
            srwf_pkg::REG_COEF_A: cfg_coef_a_ff <= csr_ch.data;
            srwf_pkg::REG_COEF_B: cfg_coef_b_ff <= csr_ch.data;
            srwf_pkg::REG_COEF_C: cfg_coef_c_ff <= csr_ch.data;
            srwf_pkg::REG_COEF_D: cfg_coef_d_ff <= csr_ch.data[47:0];
            default: ; // writes past the register list are dropped
         endcase
      end
   end

   // saturate width, height and radius into their usable ranges
   always_comb begin
      if (cfg_width_ff == '0)                   w_eff = W_W'(1);
      else if (32'(cfg_width_ff) > MAX_WIDTH)   w_eff = W_W'(MAX_WIDTH);
      else                                      w_eff = W_W'(cfg_width_ff);
      if (cfg_height_ff == '0)                  h_eff = H_W'(1);
      else if (32'(cfg_height_ff) > MAX_HEIGHT) h_eff = H_W'(MAX_HEIGHT);
      else                                      h_eff = H_W'(cfg_height_ff);
      if (32'(cfg_radius_ff) > MAX_RADIUS)      r_eff = R_W'(MAX_RADIUS);
      else                                      r_eff = R_W'(cfg_radius_ff);
   end

   // frame size and output latency, in words; products widened before the multiply
   always_ff @(posedge clock) begin
      w_ff     <= w_eff;
      h_ff     <= h_eff;
      r_ff     <= r_eff;
      total_ff <= TOT_W'(w_eff) * TOT_W'(h_eff);
      lat_ff   <= CNT_W'(r_eff) * CNT_W'(w_eff) + CNT_W'(r_eff);
   end

   srwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = cmd.req_ready;

   srwf_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.operation),
      .req_pix   (req_ch.pixel_in),
      .bypass    (cfg_bypass_ff),
      .width     (w_ff),
      .height    (h_ff),
      .radius    (r_ff),
      .total     (total_ff),
      .lat       (lat_ff),
      .coef_all  ({cfg_coef_d_ff, cfg_coef_c_ff, cfg_coef_b_ff, cfg_coef_a_ff}),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_pixel (rsp_ch.pixel_out),
      .rsp_last  (rsp_ch.frame_last)
   );

endmodule

`default_nettype wire
